@@ sv/weighted_term_sum_reduction_assert.svh @@
// Assertion helpers for the checker file.
// Both forms sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef WEIGHTED_TERM_SUM_REDUCTION_ASSERT_SVH
`define WEIGHTED_TERM_SUM_REDUCTION_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define WTSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define WTSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/wtsr_pkg.sv @@
package wtsr_pkg;

  // Number of term lanes built into the datapath
  localparam int AVAILABLE_TERMS = 4;

  // Register widths
  localparam int COUNT_W     = 3;
  localparam int MODES_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int ACC_W       = 64;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_TERM_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TERM_MODES = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_ZERO = 3'd2;

  // Term modes, two bits per term
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_SCALE   = 2'd0;
  localparam mode_t MODE_LEFT    = 2'd1;
  localparam mode_t MODE_PRODUCT = 2'd2;
  localparam mode_t MODE_IGNORE  = 2'd3;

  // Accumulator bounds
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Control that travels alongside the term data
  typedef struct packed {
    logic valid;
    logic last;
  } wtsr_ctl_t;

endpackage

@@ sv/wtsr_lane.sv @@
// One term lane: scale*left, then the second product or the alignment shift.
module wtsr_lane import wtsr_pkg::*; #(
  parameter int VALUE_BITS    = 16,
  parameter int FRACTION_BITS = 8,
  parameter int TERM_W        = 48
) (
  input  logic                         clk,
  input  logic                         advance,
  input  logic signed [VALUE_BITS-1:0] scale,
  input  logic signed [VALUE_BITS-1:0] left,
  input  logic signed [VALUE_BITS-1:0] right,
  input  mode_t                        mode,
  output logic signed [TERM_W-1:0]     term
);

  localparam int PROD1_W = 2 * VALUE_BITS;
  localparam int PROD2_W = 3 * VALUE_BITS;
  localparam int SHIFT1  = FRACTION_BITS;
  localparam int SHIFT2  = 2 * FRACTION_BITS;

  logic signed [PROD1_W-1:0]    prod1;
  logic signed [PROD1_W-1:0]    prod1_r;
  logic signed [VALUE_BITS-1:0] scale_r;
  logic signed [VALUE_BITS-1:0] right_r;
  mode_t                        mode_r;
  logic signed [PROD2_W-1:0]    prod2;
  logic signed [TERM_W-1:0]     term_nxt;
  logic signed [TERM_W-1:0]     term_r;

  // First stage: scale times left operand
  assign prod1 = scale * left;

  always_ff @(posedge clk) begin
    if (advance) begin
      prod1_r <= prod1;
      scale_r <= scale;
      right_r <= right;
      mode_r  <= mode;
    end
  end

  // Second stage: bring the chosen term to 3*FRACTION_BITS fraction bits
  assign prod2 = prod1_r * right_r;

  always_comb begin
    case (mode_r)
      MODE_SCALE:   term_nxt = TERM_W'(scale_r) <<< SHIFT2;
      MODE_LEFT:    term_nxt = TERM_W'(prod1_r) <<< SHIFT1;
      MODE_PRODUCT: term_nxt = TERM_W'(prod2);
      default:      term_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

@@ sv/wtsr_merge.sv @@
// Merging stage: adds the lane terms, saturating accumulate, result register.
module wtsr_merge import wtsr_pkg::*; #(
  parameter int TERM_W = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wtsr_ctl_t               ctl_in,
  input  logic signed [TERM_W-1:0] term [AVAILABLE_TERMS],
  output logic                    hold,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] total,
  output logic                    saturated
);

  localparam int COEF_W = TERM_W + $clog2(AVAILABLE_TERMS);
  localparam int WIDE_W = ACC_W + 1;

  wtsr_ctl_t                 ctl3_r;
  logic signed [COEF_W-1:0]  coef_nxt;
  logic signed [COEF_W-1:0]  coef_r;
  logic signed [ACC_W-1:0]   sum_r;
  logic signed [ACC_W-1:0]   sum_nxt;
  logic                      clip_r;
  logic                      clip_nxt;
  logic signed [WIDE_W-1:0]  sum_wide;
  logic                      overflow;
  logic                      load_total;
  logic                      out_valid_r;
  logic signed [ACC_W-1:0]   total_r;
  logic                      sat_r;

  // A last element cannot enter the accumulator while the previous total waits
  assign hold = ctl3_r.valid && ctl3_r.last && out_valid_r && out_stall;

  // Last element leaving the accumulator into the result register
  assign load_total = !hold && ctl3_r.valid && ctl3_r.last;

  // Lane terms summed into one coefficient
  always_comb begin
    coef_nxt = '0;
    for (int k = 0; k < AVAILABLE_TERMS; k++) begin
      coef_nxt = coef_nxt + COEF_W'(term[k]);
    end
  end

  // Saturating add, one bit wider to spot the overflow
  assign sum_wide = WIDE_W'(sum_r) + WIDE_W'(coef_r);
  assign overflow = sum_wide[WIDE_W-1] != sum_wide[WIDE_W-2];
  assign sum_nxt  = overflow ? (sum_wide[WIDE_W-1] ? ACC_MIN : ACC_MAX)
                             : sum_wide[ACC_W-1:0];
  assign clip_nxt = clip_r | overflow;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r      <= '0;
      sum_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_total) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (!hold) begin
        ctl3_r <= ctl_in;
        if (ctl3_r.valid) begin
          if (ctl3_r.last) begin
            sum_r  <= '0;
            clip_r <= 1'b0;
          end else begin
            sum_r  <= sum_nxt;
            clip_r <= clip_nxt;
          end
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!hold) begin
      coef_r <= coef_nxt;
    end
    if (load_total) begin
      total_r <= sum_nxt;
      sat_r   <= clip_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign total     = total_r;
  assign saturated = sat_r;

endmodule

@@ sv/weighted_term_sum_reduction.sv @@
// Weighted term sum reduction. One vector position is taken per clock cycle while the
// input is not stalled; each of up to four term lanes adds its scale, scale*left or
// scale*left*right, aligned to 3*FRACTION_BITS fraction bits, into a saturating 64-bit
// running sum with a sticky clip flag. A position marked last emits the total and
// clears the sum. The total is offered once the last position has passed the first
// lane stage, the second lane stage (one multiplier each), the lane-sum register and
// the result register. Input is stalled only when a new total is ready to leave the
// accumulator while the previous one still waits on a stalled output. Configuration
// must be written while no vector is in flight.
module weighted_term_sum_reduction import wtsr_pkg::*; #(
  parameter int MAX_TERMS     = 4,
  parameter int VALUE_BITS    = 16,
  parameter int FRACTION_BITS = 8,
  localparam int CFG_DATA_W   = (VALUE_BITS > MODES_W) ? VALUE_BITS : MODES_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_left_zero,
  input  logic signed [VALUE_BITS-1:0] in_right_zero,
  input  logic signed [VALUE_BITS-1:0] in_left_one,
  input  logic signed [VALUE_BITS-1:0] in_right_one,
  input  logic signed [VALUE_BITS-1:0] in_left_two,
  input  logic signed [VALUE_BITS-1:0] in_right_two,
  input  logic signed [VALUE_BITS-1:0] in_left_three,
  input  logic signed [VALUE_BITS-1:0] in_right_three,
  input  logic                         in_element_valid,
  input  logic                         in_last_element,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ACC_W-1:0]      out_total,
  output logic                         out_saturated
);

  localparam int W_PRODUCT = 3 * VALUE_BITS;
  localparam int W_SCALE   = VALUE_BITS + 2 * FRACTION_BITS;
  localparam int W_LEFT    = 2 * VALUE_BITS + FRACTION_BITS;
  localparam int W_MAX2    = (W_SCALE > W_LEFT) ? W_SCALE : W_LEFT;
  localparam int TERM_W    = (W_PRODUCT > W_MAX2) ? W_PRODUCT : W_MAX2;

  logic [COUNT_W-1:0]           term_count_r;
  logic [MODES_W-1:0]           term_modes_r;
  logic signed [VALUE_BITS-1:0] scale_r [AVAILABLE_TERMS];
  logic signed [VALUE_BITS-1:0] left_a  [AVAILABLE_TERMS];
  logic signed [VALUE_BITS-1:0] right_a [AVAILABLE_TERMS];
  mode_t                        lane_mode [AVAILABLE_TERMS];
  logic signed [TERM_W-1:0]     lane_term [AVAILABLE_TERMS];
  wtsr_ctl_t                    ctl1_r;
  wtsr_ctl_t                    ctl2_r;
  wtsr_ctl_t                    ctl1_nxt;
  logic                         hold;
  logic                         advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= '0;
      term_modes_r <= '0;
      for (int k = 0; k < AVAILABLE_TERMS; k++) begin
        scale_r[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TERM_COUNT: term_count_r <= cfg_wdata[COUNT_W-1:0];
        REG_TERM_MODES: term_modes_r <= cfg_wdata[MODES_W-1:0];
        default: begin
          for (int k = 0; k < AVAILABLE_TERMS; k++) begin
            if (cfg_index == CFG_INDEX_W'(int'(REG_SCALE_ZERO) + k)) begin
              scale_r[k] <= cfg_wdata[VALUE_BITS-1:0];
            end
          end
        end
      endcase
    end
  end

  // Operands gathered per lane
  assign left_a[0]  = in_left_zero;
  assign right_a[0] = in_right_zero;
  assign left_a[1]  = in_left_one;
  assign right_a[1] = in_right_one;
  assign left_a[2]  = in_left_two;
  assign right_a[2] = in_right_two;
  assign left_a[3]  = in_left_three;
  assign right_a[3] = in_right_three;

  assign advance  = !hold;
  assign in_stall = hold;

  // Lanes past the term count, or a position that adds nothing, are ignored
  for (genvar k = 0; k < AVAILABLE_TERMS; k++) begin : g_lane
    logic lane_on;
    assign lane_on = (k < MAX_TERMS) && (COUNT_W'(k) < term_count_r);
    assign lane_mode[k] = (in_element_valid && lane_on) ? mode_t'(term_modes_r[2*k +: 2])
                                                        : MODE_IGNORE;

    wtsr_lane #(
      .VALUE_BITS    (VALUE_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .TERM_W        (TERM_W)
    ) u_lane (
      .clk     (clk),
      .advance (advance),
      .scale   (scale_r[k]),
      .left    (left_a[k]),
      .right   (right_a[k]),
      .mode    (lane_mode[k]),
      .term    (lane_term[k])
    );
  end

  // Control follows the lane pipeline
  always_comb begin
    ctl1_nxt.valid = in_valid;
    ctl1_nxt.last  = in_last_element;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (advance) begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
    end
  end

  wtsr_merge #(
    .TERM_W (TERM_W)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl2_r),
    .term      (lane_term),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .total     (out_total),
    .saturated (out_saturated)
  );

endmodule

@@ sv/wtsr_checker.sv @@
`include "weighted_term_sum_reduction_assert.svh"

// Port-level checks on the reduction block
module wtsr_checker import wtsr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ACC_W-1:0]  out_total,
  input logic              out_saturated
);

  // A stalled result holds
  `WTSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_total) && $stable(out_saturated), "result changed while stalled")

  // Input is only stalled by a waiting, stalled result
  `WTSR_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")

  // A new total only leaves when the pipeline was moving
  `WTSR_ASSERT_SAME(a_load_moving, $rose(out_valid), $past(!in_stall), "total loaded while pipeline held")

endmodule

bind weighted_term_sum_reduction wtsr_checker u_wtsr_checker (.*);

@@ bench/weighted_term_sum_reduction_test.sv @@
`timescale 1ns / 100ps

module weighted_term_sum_reduction_test import wtsr_pkg::*; ();

  localparam int VALUE_BITS    = 16;
  localparam int FRAC_BITS     = 8;
  localparam int TERM_LIMIT    = 4;
  localparam int CFG_DATA_W    = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic [15:0] VMAX = 16'h7FFF;
  localparam logic [15:0] VMIN = 16'h8000;
  localparam logic [15:0] Z    = 16'h0000;

  // One complete register setting
  typedef struct packed {
    logic [COUNT_W-1:0]     count;
    logic [MODES_W-1:0]     modes;
    logic [0:3][15:0]       scale;
  } setting_t;

  // One vector position as presented on the input channel
  typedef struct packed {
    logic [0:3][15:0] left;
    logic [0:3][15:0] right;
    logic             element_valid;
    logic             last_element;
  } position_t;

  // One emitted total
  typedef struct packed {
    logic [63:0] total;
    logic        saturated;
  } total_t;

  // Directed stimulus row; set_cfg reprograms before the row once the block is idle
  typedef struct packed {
    logic        set_cfg;
    setting_t    cfg;
    position_t   pos;
    logic        known;
    logic [63:0] known_total;
    logic        known_sat;
  } directed_row_t;

  localparam setting_t NO_CHANGE = '{3'd0, 8'h00, '{Z, Z, Z, Z}};
  localparam setting_t CLIP_SETTING = '{3'd4, 8'hAA, '{VMIN, VMIN, VMIN, VMIN}};

  localparam int PLAN_ROWS = 21;
  localparam directed_row_t PLAN [PLAN_ROWS] = '{
    // reset registers: no terms in use
    '{1'b0, NO_CHANGE, '{'{VMAX, VMAX, VMAX, VMAX}, '{VMAX, VMAX, VMAX, VMAX}, 1'b1, 1'b1},
      1'b1, 64'h0, 1'b0},
    // empty vector
    '{1'b0, NO_CHANGE, '{'{Z, Z, Z, Z}, '{Z, Z, Z, Z}, 1'b0, 1'b1},
      1'b1, 64'h0, 1'b0},
    // one term, scale only, largest scale
    '{1'b1, '{3'd1, 8'h00, '{VMAX, VMIN, VMIN, VMIN}},
      '{'{VMIN, VMIN, VMIN, VMIN}, '{VMIN, VMIN, VMIN, VMIN}, 1'b1, 1'b1},
      1'b1, 64'h0000_0000_7FFF_0000, 1'b0},
    // sum cleared after the last element
    '{1'b0, NO_CHANGE, '{'{Z, Z, Z, Z}, '{Z, Z, Z, Z}, 1'b0, 1'b1},
      1'b1, 64'h0, 1'b0},
    // four products, all at the negative extreme
    '{1'b1, CLIP_SETTING,
      '{'{VMIN, VMIN, VMIN, VMIN}, '{VMIN, VMIN, VMIN, VMIN}, 1'b1, 1'b1},
      1'b1, 64'hFFFF_8000_0000_0000, 1'b0},
    '{1'b0, NO_CHANGE, '{'{VMAX, VMAX, VMAX, VMAX}, '{VMAX, VMAX, VMAX, VMAX}, 1'b1, 1'b1},
      1'b0, 64'h0, 1'b0},
    // scaled left on all terms, multi-position vector with a skipped position
    '{1'b1, '{3'd4, 8'h55, '{VMAX, VMAX, VMAX, VMAX}},
      '{'{VMIN, VMIN, VMIN, VMIN}, '{VMAX, VMAX, VMAX, VMAX}, 1'b1, 1'b0},
      1'b0, 64'h0, 1'b0},
    '{1'b0, NO_CHANGE, '{'{VMAX, VMAX, VMAX, VMAX}, '{Z, Z, Z, Z}, 1'b0, 1'b0},
      1'b0, 64'h0, 1'b0},
    '{1'b0, NO_CHANGE,
      '{'{16'h0001, 16'h0002, 16'h0003, 16'h0004}, '{Z, Z, Z, Z}, 1'b1, 1'b0},
      1'b0, 64'h0, 1'b0},
    '{1'b0, NO_CHANGE, '{'{VMAX, VMAX, VMAX, VMAX}, '{Z, Z, Z, Z}, 1'b1, 1'b1},
      1'b0, 64'h0, 1'b0},
    // every term ignored
    '{1'b1, '{3'd4, 8'hFF, '{VMAX, VMAX, VMAX, VMAX}},
      '{'{VMAX, VMAX, VMAX, VMAX}, '{VMAX, VMAX, VMAX, VMAX}, 1'b1, 1'b1},
      1'b1, 64'h0, 1'b0},
    // count above the usable terms, one term in each mode
    '{1'b1, '{3'd7, 8'hE4, '{VMIN, VMAX, VMIN, VMAX}},
      '{'{VMIN, VMIN, VMIN, VMIN}, '{VMAX, VMAX, VMAX, VMAX}, 1'b1, 1'b0},
      1'b0, 64'h0, 1'b0},
    '{1'b0, NO_CHANGE, '{'{VMAX, VMAX, VMAX, VMAX}, '{VMIN, VMIN, VMIN, VMIN}, 1'b1, 1'b1},
      1'b0, 64'h0, 1'b0},
    // count five, modes reversed, mixed scales
    '{1'b1, '{3'd5, 8'h1B, '{16'h0100, 16'hFF00, 16'h0080, 16'h7FFF}},
      '{'{16'h0100, 16'hFF80, 16'h1234, 16'h8000},
        '{16'h0200, 16'h7FFF, 16'hEDCC, 16'h0001}, 1'b1, 1'b1},
      1'b0, 64'h0, 1'b0},
    // two scale terms cancelling to minus one in the scale unit
    '{1'b1, '{3'd2, 8'h00, '{VMIN, VMAX, 16'h0001, 16'h0001}},
      '{'{Z, Z, Z, Z}, '{Z, Z, Z, Z}, 1'b1, 1'b1},
      1'b1, 64'hFFFF_FFFF_FFFF_0000, 1'b0},
    // three terms, fourth mode set but unused
    '{1'b1, '{3'd3, 8'h26, '{16'h0001, 16'hFFFF, VMAX, VMAX}},
      '{'{VMAX, VMIN, VMIN, VMAX}, '{VMIN, Z, VMIN, VMIN}, 1'b1, 1'b0},
      1'b0, 64'h0, 1'b0},
    '{1'b0, NO_CHANGE, '{'{Z, Z, Z, Z}, '{Z, Z, Z, Z}, 1'b1, 1'b0},
      1'b0, 64'h0, 1'b0},
    '{1'b0, NO_CHANGE,
      '{'{16'h3A5C, 16'hC3A5, 16'h5AC3, 16'hA53C},
        '{16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00}, 1'b1, 1'b1},
      1'b0, 64'h0, 1'b0},
    // count zero with modes set
    '{1'b1, '{3'd0, 8'hAA, '{VMAX, VMAX, VMAX, VMAX}},
      '{'{VMAX, VMAX, VMAX, VMAX}, '{VMAX, VMAX, VMAX, VMAX}, 1'b1, 1'b1},
      1'b1, 64'h0, 1'b0},
    // vector of skipped positions only
    '{1'b0, NO_CHANGE, '{'{VMAX, VMAX, VMAX, VMAX}, '{VMAX, VMAX, VMAX, VMAX}, 1'b0, 1'b0},
      1'b0, 64'h0, 1'b0},
    '{1'b0, NO_CHANGE, '{'{VMAX, VMAX, VMAX, VMAX}, '{VMAX, VMAX, VMAX, VMAX}, 1'b0, 1'b1},
      1'b1, 64'h0, 1'b0}
  };

  // Idling per random phase, percent of cycles
  localparam int SEND_IDLE [4]  = '{0, 62, 0, 31};
  localparam int RECV_STALL [4] = '{0, 0, 62, 31};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [VALUE_BITS-1:0]  in_left_zero   = '0;
  logic signed [VALUE_BITS-1:0]  in_right_zero  = '0;
  logic signed [VALUE_BITS-1:0]  in_left_one    = '0;
  logic signed [VALUE_BITS-1:0]  in_right_one   = '0;
  logic signed [VALUE_BITS-1:0]  in_left_two    = '0;
  logic signed [VALUE_BITS-1:0]  in_right_two   = '0;
  logic signed [VALUE_BITS-1:0]  in_left_three  = '0;
  logic signed [VALUE_BITS-1:0]  in_right_three = '0;
  logic                          in_element_valid = 1'b0;
  logic                          in_last_element  = 1'b0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ACC_W-1:0] out_total;
  logic                    out_saturated;

  // Shadow registers and accumulator of the predictor
  logic [COUNT_W-1:0]  shadow_count = '0;
  logic [MODES_W-1:0]  shadow_modes = '0;
  logic signed [15:0]  shadow_scale [4] = '{default: '0};
  logic signed [63:0]  running_total = '0;
  logic                clip_flag = 1'b0;

  total_t pending_totals [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatches     = 0;

  weighted_term_sum_reduction dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_left_zero     (in_left_zero),
    .in_right_zero    (in_right_zero),
    .in_left_one      (in_left_one),
    .in_right_one     (in_right_one),
    .in_left_two      (in_left_two),
    .in_right_two     (in_right_two),
    .in_left_three    (in_left_three),
    .in_right_three   (in_right_three),
    .in_element_valid (in_element_valid),
    .in_last_element  (in_last_element),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total        (out_total),
    .out_saturated    (out_saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Weighted contribution of one position at 3*FRAC_BITS fraction bits
  function automatic logic signed [63:0] position_weight(input position_t p);
    logic signed [63:0] weight;
    logic signed [63:0] s;
    logic signed [63:0] l;
    logic signed [63:0] r;
    mode_t              m;
    int                 active;
    weight = '0;
    active = (shadow_count > TERM_LIMIT) ? TERM_LIMIT : int'(shadow_count);
    if (active > AVAILABLE_TERMS) active = AVAILABLE_TERMS;
    for (int k = 0; k < active; k++) begin
      m = shadow_modes[2*k +: 2];
      s = shadow_scale[k];
      l = signed'(p.left[k]);
      r = signed'(p.right[k]);
      case (m)
        MODE_SCALE:   weight += s <<< (2 * FRAC_BITS);
        MODE_LEFT:    weight += (s * l) <<< FRAC_BITS;
        MODE_PRODUCT: weight += s * l * r;
        default:      ;
      endcase
    end
    return weight;
  endfunction

  // Fold one accepted position into the accumulator; queue the total on the last one
  task automatic absorb_position(input position_t p, input logic known,
                                 input logic [63:0] known_total, input logic known_sat);
    logic signed [64:0] wide;
    if (p.element_valid) begin
      wide = running_total + position_weight(p);
      if (wide > $signed({1'b0, ACC_MAX})) begin
        running_total = ACC_MAX;
        clip_flag     = 1'b1;
      end else if (wide < $signed({1'b1, ACC_MIN})) begin
        running_total = ACC_MIN;
        clip_flag     = 1'b1;
      end else begin
        running_total = wide[63:0];
      end
    end
    if (p.last_element) begin
      if (known) pending_totals.push_back('{known_total, known_sat});
      else pending_totals.push_back('{running_total, clip_flag});
      running_total = '0;
      clip_flag     = 1'b0;
    end
  endtask

  // Offer one position, with random idle cycles first, and wait for the transfer
  task automatic send_position(input position_t p, input logic known,
                               input logic [63:0] known_total, input logic known_sat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_left_zero     <= p.left[0];
    in_right_zero    <= p.right[0];
    in_left_one      <= p.left[1];
    in_right_one     <= p.right[1];
    in_left_two      <= p.left[2];
    in_right_two     <= p.right[2];
    in_left_three    <= p.left[3];
    in_right_three   <= p.right[3];
    in_element_valid <= p.element_valid;
    in_last_element  <= p.last_element;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_position(p, known, known_total, known_sat);
  endtask

  // Stop offering, wait for every pending total, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_TERM_COUNT, CFG_DATA_W'(s.count));
    write_reg(REG_TERM_MODES, CFG_DATA_W'(s.modes));
    for (int k = 0; k < AVAILABLE_TERMS; k++)
      write_reg(CFG_INDEX_W'(REG_SCALE_ZERO + k), s.scale[k]);
    cfg_we <= 1'b0;
    shadow_count = s.count;
    shadow_modes = s.modes;
    for (int k = 0; k < AVAILABLE_TERMS; k++) shadow_scale[k] = s.scale[k];
  endtask

  // Operand biased towards the extremes and zero
  function automatic logic [15:0] rand_operand();
    case ($urandom_range(15))
      0:       return VMIN;
      1:       return VMAX;
      2:       return Z;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic position_t random_position();
    position_t p;
    for (int k = 0; k < 4; k++) begin
      p.left[k]  = rand_operand();
      p.right[k] = rand_operand();
    end
    p.element_valid = 1'b1;
    p.last_element  = 1'b0;
    return p;
  endfunction

  function automatic setting_t random_setting();
    setting_t s;
    s.count = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
    s.modes = 8'($urandom);
    for (int k = 0; k < 4; k++) s.scale[k] = rand_operand();
    return s;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest pending total
  always @(posedge clk) begin : result_check
    total_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_totals.size() == 0) begin
        $error("unexpected result: total %0d saturated %0b", out_total, out_saturated);
        mismatches++;
      end else begin
        want = pending_totals.pop_front();
        if (out_total !== want.total) begin
          $error("total: expected %0d, actual %0d", $signed(want.total), out_total);
          mismatches++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, out_saturated);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    position_t   p;
    int unsigned sent;
    int unsigned len;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].set_cfg) begin
        settle();
        apply_setting(PLAN[i].cfg);
      end
      send_position(PLAN[i].pos, PLAN[i].known, PLAN[i].known_total, PLAN[i].known_sat);
    end

    // Back-pressure: receiver holds off while one-position vectors keep coming
    settle();
    apply_setting('{3'd4, 8'h9C, '{VMAX, VMIN, 16'h1234, 16'hC001}});
    hold_requests++;
    @(posedge clk);
    repeat (40) begin
      p = random_position();
      p.last_element = 1'b1;
      send_position(p, 1'b0, '0, 1'b0);
    end

    // Random vectors under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      repeat (4) begin
        settle();
        apply_setting(random_setting());
        sent = 0;
        while (sent < 70) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          for (int unsigned e = 0; e < len; e++) begin
            p = random_position();
            p.element_valid = ($urandom_range(9) != 0);
            p.last_element  = (e == len - 1);
            send_position(p, 1'b0, '0, 1'b0);
          end
          sent += len;
        end
      end
    end

    settle();
    if (mismatches == 0 && pending_totals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ weighted_term_sum_reduction.f @@
+incdir+sv
sv/wtsr_pkg.sv
sv/wtsr_lane.sv
sv/wtsr_merge.sv
sv/weighted_term_sum_reduction.sv
sv/wtsr_checker.sv
bench/weighted_term_sum_reduction_test.sv
